@@ sv/pxg_pkg.sv @@
package pxg_pkg;

  localparam int unsigned CoeffCount = 3;
  localparam int unsigned CoeffWidth = 64;
  localparam int unsigned DegWidth   = 3;
  localparam logic [DegWidth-1:0] DegNone = 3'b111;

  typedef enum logic [4:0] {
    StIdle,
    StLoadMod,
    StLoadTrim,
    StCheck,
    StInvInit,
    StInvSq,
    StInvMul,
    StInvStep,
    StQuot,
    StUpdMul,
    StUpdSub,
    StTrim,
    StOut
  } pxg_state_e;

  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpSwap,
    OpInvInit,
    OpInvSq,
    OpInvMul,
    OpQuot,
    OpUpd
  } pxg_op_e;

  typedef struct packed {
    pxg_op_e      op;
    logic [3:0]   sel;
    logic         mod_start;
    logic         mul_start;
    logic         trim;
    logic         clear;
  } pxg_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       r_zero;
    logic       r_higher;
    logic       exp_zero;
    logic       exp_bit;
    logic       mod_small;
  } pxg_stat_t;

endpackage

@@ sv/pxg_if.sv @@
interface pxg_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/poly_xgcd_deg2_gf_p.sv @@
// Extended Euclid over GF(p) for polynomials of degree at most two.
// Channels: in_if carries the two input polynomials as one word, out_if the
// gcd and both cofactors as one word, cfg_if writes the prime modulus (reset
// value 3); the user must write it only while the block is idle, which the
// block itself does not enforce. One word is processed at a time: in_if.ready
// is high only in idle. The work runs on a single bit-serial modular
// multiplier. Loading takes six reductions; each Euclid round takes a modular
// inverse by square-and-multiply, up to 128 multiplies, and then a quotient
// multiply and nine update multiplies. The result stays on out_if with valid
// high until taken; while the sink stalls no new word is accepted. Reset
// returns to idle with no result pending and the modulus at 3.
module poly_xgcd_deg2_gf_p #(
  parameter int unsigned CoeffWidth = pxg_pkg::CoeffWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  pxg_if.sink   cfg_if,
  pxg_if.sink   in_if,
  pxg_if.source out_if
);
  import pxg_pkg::*;

  logic [CoeffWidth-1:0] p_q;
  pxg_cmd_t  cmd;
  pxg_stat_t stat;
  logic      cap;
  logic [2:0] a_deg_q, b_deg_q;
  logic [2:0][CoeffWidth-1:0] a_c_q, b_c_q;
  logic [2:0] gd, m1d, m2d;
  logic [2:0][CoeffWidth-1:0] gc, m1c, m2c;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_q <= CoeffWidth'(3);
    else if (cfg_if.valid) p_q <= cfg_if.data[CoeffWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      a_deg_q <= in_if.data[2:0];
      a_c_q   <= in_if.data[3 +: 3*CoeffWidth];
      b_deg_q <= in_if.data[3+3*CoeffWidth +: 3];
      b_c_q   <= in_if.data[6+3*CoeffWidth +: 3*CoeffWidth];
    end
  end

  pxg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .stat_i(stat), .cap_o(cap)
  );

  pxg_cmd_t dcmd;
  always_comb begin
    dcmd = cmd;
    dcmd.clear = cap;
  end

  pxg_datapath #(.CoeffWidth(CoeffWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dcmd), .stat_o(stat), .p_i(p_q),
    .a_deg_i(a_deg_q), .a_c_i(a_c_q), .b_deg_i(b_deg_q), .b_c_i(b_c_q),
    .g_deg_o(gd), .g_c_o(gc), .m1_deg_o(m1d), .m1_c_o(m1c),
    .m2_deg_o(m2d), .m2_c_o(m2c)
  );

  assign out_if.data = {m2c, m2d, m1c, m1d, gc, gd};
endmodule

@@ sv/pxg_mulmod.sv @@
// Bit-serial modular multiply (double and add), one bit a cycle, plus reduction
// of an arbitrary value by repeated doubling-free shift-subtract.
module pxg_mulmod #(
  parameter int unsigned CoeffWidth = pxg_pkg::CoeffWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  reduce_i,
  input  logic [CoeffWidth-1:0] a_i,
  input  logic [CoeffWidth-1:0] b_i,
  input  logic [CoeffWidth-1:0] p_i,
  output logic                  busy_o,
  output logic [CoeffWidth-1:0] res_o
);
  import pxg_pkg::*;
  localparam int unsigned CntW = $clog2(CoeffWidth + 1);

  logic [CoeffWidth-1:0] acc_q, acc_d, a_q, a_d, b_q, b_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  red_q, red_d, busy_q, busy_d;
  logic [CoeffWidth:0]   dbl, dred;
  logic [CoeffWidth-1:0] step;

  // add_m with operands already below p
  function automatic logic [CoeffWidth-1:0] addm(input logic [CoeffWidth-1:0] x,
      input logic [CoeffWidth-1:0] y, input logic [CoeffWidth-1:0] p);
    logic [CoeffWidth-1:0] pmy;
    pmy = p - y;
    addm = (x >= pmy) ? (x - pmy) : (x + y);
  endfunction

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    red_d  = red_q;
    busy_d = busy_q;
    dbl = '0; dred = '0;
    step = '0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CntW'(CoeffWidth);
      red_d  = reduce_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (red_q) begin
        // remainder: shift in one bit of b, subtract p when it fits
        dbl  = {acc_q, b_q[CoeffWidth-1]};
        dred = (dbl >= {1'b0, p_i}) ? dbl - {1'b0, p_i} : dbl;
        acc_d = dred[CoeffWidth-1:0];
      end else begin
        step = addm(acc_q, acc_q, p_i);
        acc_d = b_q[CoeffWidth-1] ? addm(step, a_q, p_i) : step;
      end
      b_d   = {b_q[CoeffWidth-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      red_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      red_q  <= red_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign busy_o = busy_q;
  assign res_o  = acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("multiplier busy with zero count");
endmodule

@@ sv/pxg_datapath.sv @@
module pxg_datapath #(
  parameter int unsigned CoeffWidth = pxg_pkg::CoeffWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pxg_pkg::pxg_cmd_t        cmd_i,
  output pxg_pkg::pxg_stat_t       stat_o,
  input  logic [CoeffWidth-1:0]    p_i,
  input  logic [2:0]               a_deg_i,
  input  logic [2:0][CoeffWidth-1:0] a_c_i,
  input  logic [2:0]               b_deg_i,
  input  logic [2:0][CoeffWidth-1:0] b_c_i,
  output logic [2:0]               g_deg_o,
  output logic [2:0][CoeffWidth-1:0] g_c_o,
  output logic [2:0]               m1_deg_o,
  output logic [2:0][CoeffWidth-1:0] m1_c_o,
  output logic [2:0]               m2_deg_o,
  output logic [2:0][CoeffWidth-1:0] m2_c_o
);
  import pxg_pkg::*;

  // polys: 0 g, 1 r, 2 m1, 3 s, 4 m2, 5 t ; degrees as signed 3-bit
  logic signed [2:0]         deg_q [6];
  logic [2:0][CoeffWidth-1:0] c_q  [6];
  logic [CoeffWidth-1:0]     inv_q, base_q, exp_q, q_q;
  logic                      mstart, mred;
  logic [CoeffWidth-1:0]     ma, mb, mres;
  logic                      mbusy;
  logic signed [2:0]         dg, dr, delta;
  logic [CoeffWidth-1:0]     lead_g, lead_r;
  logic                      mod_ok;
  logic signed [3:0]         m1_top, m2_top;

  assign dg    = deg_q[0];
  assign dr    = deg_q[1];
  assign delta = dg - dr;
  assign lead_g = (dg == 3'sd2) ? c_q[0][2] : (dg == 3'sd1) ? c_q[0][1] : c_q[0][0];
  assign lead_r = (dr == 3'sd2) ? c_q[1][2] : (dr == 3'sd1) ? c_q[1][1] : c_q[1][0];
  assign mod_ok = p_i >= CoeffWidth'(2);

  // top degree of the shifted source term, one bit wider so 2 + 2 does not wrap
  assign m1_top = 4'(deg_q[3]) + 4'(delta);
  assign m2_top = 4'(deg_q[5]) + 4'(delta);

  // sel decode: [3:2] pair (0 g/r, 1 m1/s, 2 m2/t), [1:0] source coefficient i
  logic [1:0] pair, ci;
  logic [2:0] dst, src;
  logic signed [3:0] idx;
  assign pair = cmd_i.sel[3:2];
  assign ci   = cmd_i.sel[1:0];
  assign dst  = {pair, 1'b0};
  assign src  = {pair, 1'b0} + 3'd1;
  assign idx  = $signed({2'b00, ci}) + {delta[2], delta};

  always_comb begin
    ma = '0; mb = '0; mred = 1'b0;
    case (cmd_i.op)
      OpLoad: begin
        mred = 1'b1;
        mb = cmd_i.sel[3] ? b_c_i[ci] : a_c_i[ci];
      end
      OpInvSq:  begin ma = base_q; mb = base_q; end
      OpInvMul: begin ma = inv_q;  mb = base_q; end
      OpQuot:   begin ma = lead_g; mb = inv_q;  end
      OpUpd:    begin ma = q_q;    mb = c_q[src][ci]; end
      default: ;
    endcase
  end
  assign mstart = cmd_i.mul_start;

  pxg_mulmod #(.CoeffWidth(CoeffWidth)) u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .reduce_i(mred),
    .a_i(ma), .b_i(mb), .p_i(p_i), .busy_o(mbusy), .res_o(mres)
  );

  function automatic logic [CoeffWidth-1:0] subm(input logic [CoeffWidth-1:0] x,
      input logic [CoeffWidth-1:0] y, input logic [CoeffWidth-1:0] p);
    subm = (x >= y) ? (x - y) : (x + (p - y));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) deg_q[k] <= -3'sd1;
    end else if (cmd_i.clear) begin
      for (int k = 0; k < 6; k++) deg_q[k] <= -3'sd1;
      // a modulus below two leaves every polynomial zero
      if (mod_ok) begin
        deg_q[2] <= 3'sd0;
        deg_q[5] <= 3'sd0;
      end
    end else if (cmd_i.op == OpLoad && cmd_i.sel[1:0] == 2'd0 && !cmd_i.mul_start
                 && !cmd_i.trim) begin
      // set raw degree of g (sel[3]=0) or r (sel[3]=1), clamp codes
      if (cmd_i.sel[3]) deg_q[1] <= b_deg_i[2] ? -3'sd1 : (b_deg_i == 3'd3 ? 3'sd2 : $signed(b_deg_i));
      else              deg_q[0] <= a_deg_i[2] ? -3'sd1 : (a_deg_i == 3'd3 ? 3'sd2 : $signed(a_deg_i));
    end else if (cmd_i.op == OpSwap) begin
      deg_q[0] <= deg_q[1]; deg_q[1] <= deg_q[0];
      deg_q[2] <= deg_q[3]; deg_q[3] <= deg_q[2];
      deg_q[4] <= deg_q[5]; deg_q[5] <= deg_q[4];
    end else if (cmd_i.op == OpUpd && cmd_i.trim) begin
      // cofactor degree growth for m1 and m2 before trim, saturate at two
      if (deg_q[3] >= 0 && 4'(deg_q[2]) < m1_top)
        deg_q[2] <= (m1_top > 4'sd2) ? 3'sd2 : m1_top[2:0];
      if (deg_q[5] >= 0 && 4'(deg_q[4]) < m2_top)
        deg_q[4] <= (m2_top > 4'sd2) ? 3'sd2 : m2_top[2:0];
    end else if (cmd_i.trim) begin
      for (int k = 0; k < 6; k++) begin
        if (deg_q[k] >= 0 && c_q[k][deg_q[k][1:0]] == '0) deg_q[k] <= deg_q[k] - 3'sd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      for (int k = 0; k < 6; k++) c_q[k] <= '0;
      c_q[2][0] <= mod_ok ? CoeffWidth'(1) : '0;
      c_q[5][0] <= mod_ok ? CoeffWidth'(1) : '0;
    end else if (cmd_i.op == OpSwap) begin
      c_q[0] <= c_q[1]; c_q[1] <= c_q[0];
      c_q[2] <= c_q[3]; c_q[3] <= c_q[2];
      c_q[4] <= c_q[5]; c_q[5] <= c_q[4];
    end else if (cmd_i.op == OpLoad && !mbusy && !cmd_i.mul_start && cmd_i.trim == 1'b0
                 && cmd_i.sel[2]) begin
      // sel[2] flags write-back of a finished reduction
      if ($signed({1'b0, ci}) <= (cmd_i.sel[3] ? deg_q[1] : deg_q[0]))
        c_q[cmd_i.sel[3] ? 1 : 0][ci] <= mres;
    end else if (cmd_i.op == OpUpd && !cmd_i.mul_start && !mbusy && !cmd_i.trim) begin
      if (idx >= 0 && idx < 3) begin
        if (pair == 2'd0 && idx[1:0] == dg[1:0])
          c_q[0][idx[1:0]] <= '0;
        else
          c_q[dst][idx[1:0]] <= subm(c_q[dst][idx[1:0]], mres, p_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpInvInit: begin
        inv_q  <= (p_i == CoeffWidth'(1)) ? '0 : CoeffWidth'(1);
        base_q <= lead_r;
        exp_q  <= p_i - CoeffWidth'(2);
      end
      OpInvSq: if (!cmd_i.mul_start && !mbusy) begin
        base_q <= mres;
        exp_q  <= exp_q >> 1;
      end
      OpInvMul: if (!cmd_i.mul_start && !mbusy) inv_q <= mres;
      OpQuot:   if (!cmd_i.mul_start && !mbusy) q_q <= mres;
      default: ;
    endcase
  end

  assign stat_o.busy      = mbusy;
  assign stat_o.r_zero    = deg_q[1] < 0;
  assign stat_o.r_higher  = deg_q[1] > deg_q[0];
  assign stat_o.exp_zero  = exp_q == '0;
  assign stat_o.exp_bit   = exp_q[0];
  assign stat_o.mod_small = !mod_ok;

  assign g_deg_o  = deg_q[0];
  assign g_c_o    = c_q[0];
  assign m1_deg_o = deg_q[2];
  assign m1_c_o   = c_q[2];
  assign m2_deg_o = deg_q[4];
  assign m2_c_o   = c_q[4];
endmodule

@@ sv/pxg_ctrl.sv @@
module pxg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pxg_pkg::pxg_cmd_t  cmd_o,
  input  pxg_pkg::pxg_stat_t stat_i,
  output logic               cap_o
);
  import pxg_pkg::*;

  pxg_state_e state_q, state_d;
  logic [3:0] sel_q, sel_d;
  logic       issued_q, issued_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      sel_q    <= '0;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sel_q    <= sel_d;
      issued_q <= issued_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    sel_d    = sel_q;
    issued_d = issued_q;
    cmd_o    = '{op: OpNone, sel: '0, mod_start: 1'b0, mul_start: 1'b0, trim: 1'b0,
                 clear: 1'b0};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cap_o       = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cap_o = 1'b1;
          state_d = StLoadMod;
          sel_d = 4'b0000;
          issued_d = 1'b0;
        end
      end
      StLoadMod: begin
        // sel: [3] which input, [1:0] coeff; degree set on first entry
        cmd_o.op = OpLoad;
        if (sel_q[1:0] == 2'd0 && !issued_q && !sel_q[2]) begin
          if (stat_i.mod_small) begin
            // skip loading, the cleared polynomials are the result
            cmd_o.op = OpNone;
            state_d = StOut;
          end else begin
            cmd_o.sel = {sel_q[3], 3'b000};
            sel_d = {sel_q[3], 1'b1, 2'b00};
          end
        end else if (!issued_q) begin
          cmd_o.sel = {sel_q[3], 1'b0, sel_q[1:0]};
          cmd_o.mul_start = 1'b1;
          issued_d = 1'b1;
        end else if (!stat_i.busy) begin
          cmd_o.sel = {sel_q[3], 1'b1, sel_q[1:0]};
          issued_d = 1'b0;
          if (sel_q[1:0] == 2'd2) begin
            if (sel_q[3]) state_d = StLoadTrim;
            sel_d = {~sel_q[3], 3'b000};
          end else sel_d = {sel_q[3], 1'b1, sel_q[1:0] + 2'd1};
        end
      end
      StLoadTrim: begin
        cmd_o.trim = 1'b1;
        sel_d = sel_q + 4'd1;
        if (sel_q[1:0] == 2'd2) begin
          sel_d = '0;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.r_zero) state_d = StOut;
        else if (stat_i.r_higher) cmd_o.op = OpSwap;
        else begin
          cmd_o.op = OpInvInit;
          state_d = StInvStep;
        end
      end
      StInvStep: begin
        if (stat_i.exp_zero) begin
          state_d = StQuot;
          issued_d = 1'b0;
        end else if (stat_i.exp_bit) state_d = StInvMul;
        else state_d = StInvSq;
      end
      StInvMul: begin
        cmd_o.op = OpInvMul;
        if (!issued_q) begin
          cmd_o.mul_start = 1'b1; issued_d = 1'b1;
        end else if (!stat_i.busy) begin
          issued_d = 1'b0; state_d = StInvSq;
        end
      end
      StInvSq: begin
        cmd_o.op = OpInvSq;
        if (!issued_q) begin
          cmd_o.mul_start = 1'b1; issued_d = 1'b1;
        end else if (!stat_i.busy) begin
          issued_d = 1'b0; state_d = StInvStep;
        end
      end
      StQuot: begin
        cmd_o.op = OpQuot;
        if (!issued_q) begin
          cmd_o.mul_start = 1'b1; issued_d = 1'b1;
        end else if (!stat_i.busy) begin
          issued_d = 1'b0; state_d = StUpdMul; sel_d = '0;
        end
      end
      StUpdMul: begin
        // for each pair, each source coefficient: multiply then subtract
        cmd_o.op = OpUpd;
        cmd_o.sel = sel_q;
        if (!issued_q) begin
          cmd_o.mul_start = 1'b1; issued_d = 1'b1;
        end else if (!stat_i.busy) begin
          issued_d = 1'b0;
          if (sel_q[1:0] == 2'd2) begin
            if (sel_q[3:2] == 2'd2) begin
              state_d = StUpdSub; sel_d = '0;
            end else sel_d = {sel_q[3:2] + 2'd1, 2'b00};
          end else sel_d = sel_q + 4'd1;
        end
      end
      StUpdSub: begin
        cmd_o.op = OpUpd;
        cmd_o.trim = 1'b1;
        state_d = StTrim;
      end
      StTrim: begin
        cmd_o.trim = 1'b1;
        sel_d = sel_q + 4'd1;
        if (sel_q[1:0] == 2'd2) begin
          sel_d = '0; state_d = StCheck;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("accept while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |=> stat_i.busy)
    else $error("multiplier did not start");
endmodule

@@ tb/sv/poly_xgcd_deg2_gf_p_test.sv @@
`timescale 1ns / 1ps

module poly_xgcd_deg2_gf_p_test;

  localparam int unsigned CW         = pxg_pkg::CoeffWidth;
  localparam int unsigned DW         = pxg_pkg::DegWidth;
  localparam int unsigned StallLimit = 200000;
  localparam int unsigned HoldCycles = 3000;
  localparam logic [63:0] PMaxPrime  = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [63:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;

  // first member sits in the top bits: degree lands in the low bits of the word
  typedef struct packed {
    logic [CW-1:0] c2;
    logic [CW-1:0] c1;
    logic [CW-1:0] c0;
    logic [DW-1:0] deg;
  } poly_word_t;

  typedef struct packed {
    poly_word_t b;
    poly_word_t a;
  } pair_word_t;

  typedef struct packed {
    poly_word_t cof_b;
    poly_word_t cof_a;
    poly_word_t gcd;
  } xgcd_word_t;

  typedef struct {
    int              deg;
    logic [2:0][63:0] c;
  } gf_poly_t;

  typedef struct {
    logic [63:0] p;
    pair_word_t  in;
    bit          typed;
    xgcd_word_t  res;
  } vec_row_t;

  logic clk_i;
  logic rst_ni;

  pxg_if #(.Width(64))              cfg_if ();
  pxg_if #(.Width($bits(pair_word_t))) in_if ();
  pxg_if #(.Width($bits(xgcd_word_t))) out_if ();

  poly_xgcd_deg2_gf_p u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  logic [63:0] field_p;
  xgcd_word_t  pending_results[$];
  int          errors;
  bit          in_taken, cfg_taken, out_taken;
  bit          calm;
  bit          hold_req;
  int          hold_cnt;
  bit          next_typed;
  xgcd_word_t  next_res;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------- field arithmetic ----------------
  function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b);
    return (a >= field_p - b) ? a - (field_p - b) : a + b;
  endfunction

  function automatic logic [63:0] sub_mod(logic [63:0] a, logic [63:0] b);
    return (a >= b) ? a - b : a + (field_p - b);
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = add_mod(r, r);
      if (b[i]) r = add_mod(r, a);
    end
    return r;
  endfunction

  function automatic logic [63:0] inv_mod(logic [63:0] a);
    logic [63:0] e, r, b;
    e = field_p - 64'd2;
    r = 64'd1 % field_p;
    b = a;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b);
      b = mul_mod(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic gf_poly_t trim_poly(gf_poly_t x);
    while (x.deg >= 0 && x.c[x.deg] == 0) x.deg--;
    return x;
  endfunction

  function automatic gf_poly_t load_poly(poly_word_t w);
    gf_poly_t    x;
    logic [63:0] raw [3];
    int          d;
    raw[0] = w.c0;
    raw[1] = w.c1;
    raw[2] = w.c2;
    d = int'(w.deg);
    if (d >= 4) d = -1;
    else if (d > 2) d = 2;
    x.deg = d;
    for (int i = 0; i < 3; i++) x.c[i] = (i <= d) ? raw[i] % field_p : '0;
    return trim_poly(x);
  endfunction

  // m -= q * x^delta * s, clipped to degree two
  function automatic gf_poly_t cofactor_sub(gf_poly_t m, gf_poly_t s, int delta,
                                            logic [63:0] q);
    for (int i = 0; i <= s.deg; i++) begin
      if (i + delta < 3) m.c[i + delta] = sub_mod(m.c[i + delta], mul_mod(q, s.c[i]));
    end
    if (s.deg >= 0 && m.deg < s.deg + delta) begin
      m.deg = s.deg + delta;
      if (m.deg > 2) m.deg = 2;
    end
    return trim_poly(m);
  endfunction

  function automatic poly_word_t pack_poly(gf_poly_t x);
    poly_word_t w;
    w.deg = x.deg[DW-1:0];
    w.c0  = x.c[0];
    w.c1  = x.c[1];
    w.c2  = x.c[2];
    return w;
  endfunction

  function automatic xgcd_word_t predict_xgcd(pair_word_t in);
    gf_poly_t    g, r, m1, s, m2, t, tmp;
    xgcd_word_t  res;
    int          delta;
    logic [63:0] q;
    g.deg = -1;
    g.c   = '0;
    r = g; m1 = g; s = g; m2 = g; t = g;
    if (field_p >= 2) begin
      g = load_poly(in.a);
      r = load_poly(in.b);
      m1.deg = 0; m1.c[0] = 64'd1;
      t.deg  = 0; t.c[0]  = 64'd1;
      while (r.deg >= 0) begin
        if (r.deg > g.deg) begin
          tmp = g;  g = r;   r = tmp;
          tmp = m1; m1 = s;  s = tmp;
          tmp = m2; m2 = t;  t = tmp;
        end else begin
          delta = g.deg - r.deg;
          q = mul_mod(g.c[g.deg], inv_mod(r.c[r.deg]));
          for (int i = 0; i <= r.deg; i++) begin
            // force the cancelled lead to zero even when p is composite
            if (i + delta == g.deg) g.c[i + delta] = '0;
            else g.c[i + delta] = sub_mod(g.c[i + delta], mul_mod(q, r.c[i]));
          end
          g  = trim_poly(g);
          m1 = cofactor_sub(m1, s, delta, q);
          m2 = cofactor_sub(m2, t, delta, q);
        end
      end
    end
    res.gcd   = pack_poly(g);
    res.cof_a = pack_poly(m1);
    res.cof_b = pack_poly(m2);
    return res;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic check_poly(string name, poly_word_t got, poly_word_t want);
    if (got.deg !== want.deg) report_mismatch({name, ".deg"}, 64'(got.deg), 64'(want.deg));
    if (got.c0 !== want.c0) report_mismatch({name, ".c0"}, got.c0, want.c0);
    if (got.c1 !== want.c1) report_mismatch({name, ".c1"}, got.c1, want.c1);
    if (got.c2 !== want.c2) report_mismatch({name, ".c2"}, got.c2, want.c2);
  endtask

  always @(posedge clk_i) begin
    xgcd_word_t got, want;
    in_taken  = in_if.valid && in_if.ready;
    cfg_taken = cfg_if.valid && cfg_if.ready;
    out_taken = out_if.valid && out_if.ready;
    if (cfg_taken) field_p = cfg_if.data;
    if (in_taken) begin
      pending_results.push_back(next_typed ? next_res : predict_xgcd(in_if.data));
    end
    if (out_taken) begin
      got = out_if.data;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, gcd.c0", got.gcd.c0, '0);
      end else begin
        want = pending_results.pop_front();
        check_poly("gcd", got.gcd, want.gcd);
        check_poly("cof_a", got.cof_a, want.cof_a);
        check_poly("cof_b", got.cof_b, want.cof_b);
      end
    end
    if (!rst_ni || in_taken || cfg_taken || out_taken) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- output side ----------------
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt == 0) hold_cnt = HoldCycles;
    if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_req = 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  // ---------------- input side ----------------
  task automatic write_modulus(logic [63:0] p);
    // drop the last word so it is not taken again once the block idles
    in_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= p;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_pair(pair_word_t w, bit typed, xgcd_word_t res);
    if (!calm && $urandom_range(99) < 35) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    next_typed   = typed;
    next_res     = res;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(negedge clk_i); while (!in_taken);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic poly_word_t rand_poly();
    poly_word_t w;
    int         d;
    w.c0 = rand_word();
    w.c1 = rand_word();
    w.c2 = rand_word();
    if ($urandom_range(9) < 8) begin
      // well formed: reduced coefficients, nonzero lead
      d = int'($urandom_range(3)) - 1;
      w.deg = d[DW-1:0];
      if (field_p < 64'd1000) begin
        w.c0 = 64'($urandom_range(int'(field_p) - 1));
        w.c1 = 64'($urandom_range(int'(field_p) - 1));
        w.c2 = 64'($urandom_range(int'(field_p) - 1));
      end else begin
        w.c0 = w.c0 % field_p;
        w.c1 = w.c1 % field_p;
        w.c2 = w.c2 % field_p;
      end
      if (d == 0 && w.c0 == 0) w.c0 = 64'd1;
      if (d == 1 && w.c1 == 0) w.c1 = 64'd1;
      if (d == 2 && w.c2 == 0) w.c2 = 64'd1;
    end else begin
      w.deg = DW'($urandom_range(7));
    end
    return w;
  endfunction

  function automatic poly_word_t pw(logic [2:0] d, logic [63:0] c0, logic [63:0] c1,
                                    logic [63:0] c2);
    poly_word_t w;
    w.deg = d; w.c0 = c0; w.c1 = c1; w.c2 = c2;
    return w;
  endfunction

  vec_row_t    vectors[$];
  logic [63:0] phase_p [10] = '{64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd9, 64'd65521,
                                64'h1FFF_FFFF_FFFF_FFFF, PMaxPrime, AllOnes};
  int          phase_n [10] = '{45, 45, 40, 40, 35, 30, 25, 15, 10, 10};

  initial begin
    vec_row_t   row;
    pair_word_t w;
    errors       = 0;
    field_p      = 64'd3;
    calm         = 1'b0;
    hold_req     = 1'b0;
    hold_cnt     = 0;
    next_typed   = 1'b0;
    next_res     = '0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;

    // both zero: gcd zero, cofactor of A is one
    row.p = 64'd3; row.typed = 1'b1;
    row.in  = '{a: pw(3'd7, 1, 2, 1), b: pw(3'd4, 2, 2, 2)};
    row.res = '{gcd: pw(3'd7, 0, 0, 0), cof_a: pw(3'd0, 1, 0, 0), cof_b: pw(3'd7, 0, 0, 0)};
    vectors.push_back(row);
    // constant against zero
    row.in  = '{a: pw(3'd0, 2, 0, 0), b: pw(3'd7, 0, 0, 0)};
    row.res = '{gcd: pw(3'd0, 2, 0, 0), cof_a: pw(3'd0, 1, 0, 0), cof_b: pw(3'd7, 0, 0, 0)};
    vectors.push_back(row);
    // zero against constant: swap
    row.in  = '{a: pw(3'd7, 0, 0, 0), b: pw(3'd0, 1, 0, 0)};
    row.res = '{gcd: pw(3'd0, 1, 0, 0), cof_a: pw(3'd7, 0, 0, 0), cof_b: pw(3'd0, 1, 0, 0)};
    vectors.push_back(row);
    row.typed = 1'b0;
    row.in = '{a: pw(3'd3, 1, 2, 1), b: pw(3'd2, 2, 0, 1)};      // degree 3 read as 2
    vectors.push_back(row);
    row.in = '{a: pw(3'd2, 5, 4, 3), b: pw(3'd1, 7, 11, 0)};     // unreduced, lead trims
    vectors.push_back(row);
    row.in = '{a: pw(3'd1, 1, 1, 0), b: pw(3'd2, 1, 0, 1)};      // B higher: swap first
    vectors.push_back(row);
    row.in = '{a: pw(3'd5, 1, 1, 1), b: pw(3'd6, 1, 1, 1)};      // negative degrees
    vectors.push_back(row);
    row.p = 64'd7;
    row.in = '{a: pw(3'd2, 2, 3, 1), b: pw(3'd2, 3, 4, 1)};      // common factor x+1
    vectors.push_back(row);
    row.in = '{a: pw(3'd2, 1, 2, 3), b: pw(3'd2, 1, 2, 3)};      // equal
    vectors.push_back(row);
    row.in = '{a: pw(3'd1, 6, 6, AllOnes), b: pw(3'd2, 1, 0, 6)};
    vectors.push_back(row);
    row.p = PMaxPrime;
    row.in = '{a: pw(3'd2, AllOnes, AllOnes, AllOnes), b: pw(3'd2, AllOnes, 0, AllOnes)};
    vectors.push_back(row);
    row.in = '{a: pw(3'd2, PMaxPrime - 1, 1, PMaxPrime - 1), b: pw(3'd1, 1, PMaxPrime - 1, 0)};
    vectors.push_back(row);
    row.p = AllOnes;                                             // composite modulus
    row.in = '{a: pw(3'd2, 64'h5555, 3, AllOnes - 1), b: pw(3'd1, 7, AllOnes - 3, 0)};
    vectors.push_back(row);
    row.p = 64'd9;
    row.in = '{a: pw(3'd2, 1, 0, 3), b: pw(3'd1, 2, 6, 0)};      // lead not invertible
    vectors.push_back(row);
    row.in = '{a: pw(3'd2, 4, 0, 1), b: pw(3'd2, 8, 3, 6)};
    vectors.push_back(row);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (vectors[i]) begin
      if (vectors[i].p != field_p) write_modulus(vectors[i].p);
      send_pair(vectors[i].in, vectors[i].typed, vectors[i].res);
    end

    for (int ph = 0; ph < 10; ph++) begin
      write_modulus(phase_p[ph]);
      calm = (ph == 3);
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < phase_n[ph]; k++) begin
        w.a = rand_poly();
        w.b = rand_poly();
        send_pair(w, 1'b0, '0);
      end
    end
    in_if.valid <= 1'b0;
    calm = 1'b0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pxg_pkg.sv
sv/pxg_if.sv
sv/pxg_mulmod.sv
sv/pxg_datapath.sv
sv/pxg_ctrl.sv
sv/poly_xgcd_deg2_gf_p.sv
tb/sv/poly_xgcd_deg2_gf_p_test.sv
